>>> design/easing_curve_evaluator_assert.svh
// Assertion macros shared by the easing curve evaluator RTL.
// Depends on: a clock named clk and an active-low reset named rst_n in scope.
`ifndef EASING_CURVE_EVALUATOR_ASSERT_SVH
`define EASING_CURVE_EVALUATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ECE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ECE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ece_pkg.sv
// Shared types, widths and constant tables for the easing curve evaluator.
// Depends on: nothing.
package ece_pkg;

    localparam int TIME_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FW         = FRAC_BITS + 1;   // fraction, 1.0 exact
    localparam int EW         = FRAC_BITS + 3;   // signed eased fraction

    localparam logic [FW-1:0] ONE_Q   = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] HALF_Q  = FW'(1) << (FRAC_BITS - 1);
    localparam logic [16:0]   BACK_S  = 17'd111514;   // 1.70158
    localparam logic [17:0]   BACK_S1 = 18'd177050;   // 2.70158
    // floor(10*f/3) = (f * THIRD_MUL) >> 21 for f up to 1.0
    localparam logic [22:0]   THIRD_MUL   = 23'd6990510;
    localparam logic [15:0]   PHASE_QTR   = 16'd49152;

    localparam logic [19:0] BNC_K1 = 20'd262144;   // 4.0
    localparam logic [19:0] BNC_K2 = 20'd524288;   // 8.0
    localparam logic [19:0] BNC_K3 = 20'd655360;   // 10.0
    localparam logic [20:0] BNC_C1 = 21'd393216;   // 6.0
    localparam logic [20:0] BNC_C2 = 21'd589824;   // 9.0
    localparam logic [20:0] BNC_C3 = 21'd688128;   // 10.5
    localparam logic [15:0] BNC_B1 = 16'd49152;    // .75
    localparam logic [15:0] BNC_B2 = 16'd61440;    // .9375
    localparam logic [15:0] BNC_B3 = 16'd64512;    // .984375

    localparam logic [FW-1:0] SINE_TAB [17] = '{
        17'd0, 17'd6424, 17'd12785, 17'd19024, 17'd25080, 17'd30893,
        17'd36410, 17'd41576, 17'd46341, 17'd50660, 17'd54491, 17'd57798,
        17'd60547, 17'd62714, 17'd64277, 17'd65220, 17'd65536
    };

    localparam logic [FW-1:0] POW_TAB [17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    typedef enum logic [2:0] {
        MODE_LINEAR   = 3'd0,
        MODE_IN_QUAD  = 3'd1,
        MODE_OUT_QUAD = 3'd2,
        MODE_IO_QUAD  = 3'd3,
        MODE_OUT_BACK = 3'd4,
        MODE_OUT_ELAS = 3'd5,
        MODE_OUT_BNC  = 3'd6,
        MODE_SPARE    = 3'd7
    } ece_mode_t;

    typedef struct packed {
        logic [2:0]                   mode;
        logic [TIME_BITS-1:0]         elapsed;
        logic [TIME_BITS-1:0]         span;
        logic signed [VALUE_BITS-1:0] start_value;
        logic signed [VALUE_BITS-1:0] delta_value;
    } ece_in_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] eased_value;
        logic                         saturated;
    } ece_out_t;

    // word fields that ride along the pipeline
    typedef struct packed {
        logic [2:0]                   mode;
        logic signed [VALUE_BITS-1:0] start_value;
        logic signed [VALUE_BITS-1:0] delta_value;
    } ece_carry_t;

endpackage

>>> design/ece_divider.sv
// Pipelined restoring divider: fraction = floor(min(elapsed,span) * 2^16 / span).
// Depends on: ece_pkg, easing_curve_evaluator_assert.svh.
`include "easing_curve_evaluator_assert.svh"
module ece_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [ece_pkg::TIME_BITS-1:0]     in_elapsed,
    input  logic [ece_pkg::TIME_BITS-1:0]     in_span,
    input  ece_pkg::ece_carry_t               in_carry,
    output logic                              out_valid,
    output logic [ece_pkg::FW-1:0]            out_frac,
    output logic                              out_zero,
    output ece_pkg::ece_carry_t               out_carry
);
    import ece_pkg::*;

    localparam int NS = FW + 1;   // clamp stage plus one stage per quotient bit

    logic [NS-1:0]        valid_reg;
    logic [TIME_BITS-1:0] rem_reg   [NS];
    logic [TIME_BITS-1:0] div_reg   [NS];
    logic [FW-1:0]        quo_reg   [NS];
    logic                 zero_reg  [NS];
    ece_carry_t           carry_reg [NS];
    logic                 lsb_reg;

    logic [TIME_BITS-1:0] clamp_t;
    logic [TIME_BITS:0]   trial [FW];
    logic [TIME_BITS:0]   diff  [FW];
    logic                 ge    [FW];
    logic [TIME_BITS-1:0] rem_next [FW];
    logic [FW-1:0]        quo_next [FW];

    assign clamp_t = (in_elapsed > in_span) ? in_span : in_elapsed;

    always_comb
    begin
        for (int k = 0; k < FW; k++)
        begin
            // only the first step pulls in a dividend bit; the rest shift in zero
            trial[k]    = {rem_reg[k], (k == 0) ? lsb_reg : 1'b0};
            diff[k]     = trial[k] - {1'b0, div_reg[k]};
            ge[k]       = trial[k] >= {1'b0, div_reg[k]};
            rem_next[k] = ge[k] ? diff[k][TIME_BITS-1:0] : trial[k][TIME_BITS-1:0];
            quo_next[k] = {quo_reg[k][FW-2:0], ge[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[NS-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= clamp_t >> 1;
            lsb_reg      <= clamp_t[0];
            div_reg[0]   <= in_span;
            quo_reg[0]   <= '0;
            zero_reg[0]  <= (in_span == '0);
            carry_reg[0] <= in_carry;
            for (int k = 0; k < FW; k++)
            begin
                rem_reg[k+1]   <= rem_next[k];
                quo_reg[k+1]   <= quo_next[k];
                div_reg[k+1]   <= div_reg[k];
                zero_reg[k+1]  <= zero_reg[k];
                carry_reg[k+1] <= carry_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign out_frac  = quo_reg[NS-1];
    assign out_zero  = zero_reg[NS-1];
    assign out_carry = carry_reg[NS-1];

    // clamped time never gives a fraction above 1.0
    `ECE_ASSERT_IMP(a_frac_range, out_valid && !out_zero, out_frac <= ONE_Q, "fraction above one")
    // a frozen pipeline keeps its last stage
    `ECE_ASSERT_NXT(a_div_hold, !en, $stable(out_valid), "divider moved while frozen")

endmodule

>>> design/ece_shaper.sv
// Easing curve shaper: five register stages from fraction to eased fraction.
// Depends on: ece_pkg.
module ece_shaper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ece_pkg::FW-1:0]        in_frac,
    input  logic                          in_zero,
    input  ece_pkg::ece_carry_t           in_carry,
    output logic                          out_valid,
    output logic signed [ece_pkg::EW-1:0] out_ease,
    output ece_pkg::ece_carry_t           out_carry
);
    import ece_pkg::*;

    logic [4:0] valid_reg;

    // ---- stage A: products of f and g, table lookups, bounce segment
    logic [FW-1:0]   g_a;
    logic [19:0]     ten_a, f11_a;
    logic [39:0]     ph_prod_a;
    logic [3:0]      pidx_a;
    logic [16:0]     pdiff_a;
    logic [20:0]     w_a;
    logic [15:0]     base_a;
    logic [17:0]     abs_a;

    logic [2*FW-1:0] ff_reg, gg_reg;
    logic [FW+17:0]  s1g_reg;
    logic [15:0]     ph_reg;
    logic [3:0]      pidx_reg, pshift_reg;
    logic [23:0]     pprod_reg;
    logic [17:0]     babs_reg;
    logic [15:0]     base_reg;
    logic [FW-1:0]   f_a_reg;
    logic            zero_a_reg;
    ece_carry_t      carry_a_reg;

    always_comb
    begin
        g_a       = ONE_Q - in_frac;
        ten_a     = ({3'b0, in_frac} << 3) + ({3'b0, in_frac} << 1);
        f11_a     = ten_a + {3'b0, in_frac};
        ph_prod_a = in_frac * THIRD_MUL;
        pidx_a    = ten_a[15:12];
        pdiff_a   = POW_TAB[{1'b0, pidx_a}] - POW_TAB[{1'b0, pidx_a} + 5'd1];
        priority if (f11_a < BNC_K1)
        begin
            w_a    = {1'b0, f11_a};
            base_a = '0;
        end
        else if (f11_a < BNC_K2)
        begin
            w_a    = {1'b0, f11_a} - BNC_C1;
            base_a = BNC_B1;
        end
        else if (f11_a < BNC_K3)
        begin
            w_a    = {1'b0, f11_a} - BNC_C2;
            base_a = BNC_B2;
        end
        else
        begin
            w_a    = {1'b0, f11_a} - BNC_C3;
            base_a = BNC_B3;
        end
        abs_a = w_a[20] ? 18'(-w_a) : w_a[17:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ff_reg      <= in_frac * in_frac;
            gg_reg      <= g_a * g_a;
            s1g_reg     <= BACK_S1 * g_a;
            ph_reg      <= ph_prod_a[36:21];
            pidx_reg    <= pidx_a;
            pshift_reg  <= ten_a[19:16];
            pprod_reg   <= pdiff_a[11:0] * ten_a[11:0];
            babs_reg    <= abs_a;
            base_reg    <= base_a;
            f_a_reg     <= in_frac;
            zero_a_reg  <= in_zero;
            carry_a_reg <= in_carry;
        end
    end

    // ---- stage B: rounding of squares, power of two, sine interpolation
    logic [2*FW:0]   rff_s, rgg_s, rff2_s, rgg2_s, rs1g_s;
    logic [FW-1:0]   rff_b, rgg_b, rff2_b, rgg2_b;
    logic [17:0]     rs1g_b;
    logic [EW-1:0]   esimp_b;
    logic [24:0]     pround_b;
    logic [FW-1:0]   pval_b;
    logic [15:0]     phase_b;
    logic [14:0]     x_b;
    logic [4:0]      si_b;
    logic [16:0]     sdiff_b;

    logic signed [EW-1:0] esimp_reg;
    logic [FW-1:0]        t1_reg;
    logic signed [18:0]   t2_reg;
    logic [FW-1:0]        pw_reg;
    logic [4:0]           si_reg;
    logic                 sneg_reg;
    logic [22:0]          sprod_reg;
    logic [35:0]          bsq_reg;
    logic [15:0]          base_b_reg;
    logic [FW-1:0]        f_b_reg;
    logic                 zero_b_reg;
    ece_carry_t           carry_b_reg;

    always_comb
    begin
        rff_s  = {1'b0, ff_reg} + (2*FW+1)'(32768);
        rgg_s  = {1'b0, gg_reg} + (2*FW+1)'(32768);
        rff2_s = {ff_reg, 1'b0} + (2*FW+1)'(32768);
        rgg2_s = {gg_reg, 1'b0} + (2*FW+1)'(32768);
        rs1g_s = s1g_reg[2*FW:0] + (2*FW+1)'(32768);
        rff_b  = rff_s[16 +: FW];
        rgg_b  = rgg_s[16 +: FW];
        rff2_b = rff2_s[16 +: FW];
        rgg2_b = rgg2_s[16 +: FW];
        rs1g_b = rs1g_s[16 +: 18];

        unique case (ece_mode_t'(carry_a_reg.mode))
            MODE_IN_QUAD:  esimp_b = EW'(rff_b);
            MODE_OUT_QUAD: esimp_b = EW'(ONE_Q - rgg_b);
            MODE_IO_QUAD:  esimp_b = (f_a_reg < HALF_Q) ? EW'(rff2_b)
                                                        : EW'(ONE_Q - rgg2_b);
            default:       esimp_b = EW'(f_a_reg);
        endcase

        pround_b = {1'b0, pprod_reg} + 25'd2048;
        pval_b   = POW_TAB[{1'b0, pidx_reg}] - {4'b0, pround_b[24:12]};

        phase_b  = ph_reg + PHASE_QTR;
        x_b      = phase_b[14] ? (15'd16384 - {1'b0, phase_b[13:0]})
                               : {1'b0, phase_b[13:0]};
        si_b     = x_b[14:10];
        sdiff_b  = (si_b < 5'd16) ? (SINE_TAB[si_b + 5'd1] - SINE_TAB[si_b]) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            esimp_reg   <= esimp_b;
            t1_reg      <= rgg_b;
            t2_reg      <= $signed({2'b0, BACK_S}) - $signed({1'b0, rs1g_b});
            pw_reg      <= pval_b >> pshift_reg;
            si_reg      <= si_b;
            sneg_reg    <= phase_b[15];
            sprod_reg   <= sdiff_b[12:0] * x_b[9:0];
            bsq_reg     <= babs_reg * babs_reg;
            base_b_reg  <= base_reg;
            f_b_reg     <= f_a_reg;
            zero_b_reg  <= zero_a_reg;
            carry_b_reg <= carry_a_reg;
        end
    end

    // ---- stage C: back product, signed sine, bounce value
    logic [23:0]    sround_c;
    logic [FW-1:0]  sval_c;
    logic [36:0]    bnc_c;

    logic signed [36:0]   bprod_reg;
    logic [FW-1:0]        pw_c_reg;
    logic signed [FW:0]   sine_reg;
    logic [EW-1:0]        ebnc_reg;
    logic signed [EW-1:0] esimp_c_reg;
    logic [FW-1:0]        f_c_reg;
    logic                 zero_c_reg;
    ece_carry_t           carry_c_reg;

    always_comb
    begin
        sround_c = {1'b0, sprod_reg} + 24'd512;
        sval_c   = SINE_TAB[si_reg] + {3'b0, sround_c[23:10]};
        bnc_c    = {1'b0, bsq_reg} + 37'd524288;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bprod_reg   <= $signed({1'b0, t1_reg}) * t2_reg;
            pw_c_reg    <= pw_reg;
            sine_reg    <= sneg_reg ? -$signed({1'b0, sval_c}) : $signed({1'b0, sval_c});
            ebnc_reg    <= EW'(bnc_c[36:20]) + EW'(base_b_reg);
            esimp_c_reg <= esimp_reg;
            f_c_reg     <= f_b_reg;
            zero_c_reg  <= zero_b_reg;
            carry_c_reg <= carry_b_reg;
        end
    end

    // ---- stage D: elastic product, back rounding
    logic signed [37:0] bsum_d;

    logic signed [35:0]   pn_reg;
    logic signed [EW-1:0] eback_reg;
    logic [EW-1:0]        ebnc_d_reg;
    logic signed [EW-1:0] esimp_d_reg;
    logic [FW-1:0]        f_d_reg;
    logic                 zero_d_reg;
    ece_carry_t           carry_d_reg;

    assign bsum_d = 38'(bprod_reg) + 38'sd32768;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pn_reg      <= $signed({1'b0, pw_c_reg}) * sine_reg;
            eback_reg   <= $signed(EW'(ONE_Q)) + $signed(bsum_d[16 +: EW]);
            ebnc_d_reg  <= ebnc_reg;
            esimp_d_reg <= esimp_c_reg;
            f_d_reg     <= f_c_reg;
            zero_d_reg  <= zero_c_reg;
            carry_d_reg <= carry_c_reg;
        end
    end

    // ---- stage E: elastic rounding and final choice
    logic signed [36:0]   psum_e;
    logic signed [EW-1:0] eelas_e;
    logic signed [EW-1:0] ease_e;

    logic signed [EW-1:0] ease_reg;
    ece_carry_t           carry_e_reg;

    always_comb
    begin
        psum_e = 37'(pn_reg) + 37'sd32768;
        if (f_d_reg == '0)
            eelas_e = '0;
        else if (f_d_reg >= ONE_Q)
            eelas_e = EW'(ONE_Q);
        else
            eelas_e = $signed(EW'(ONE_Q)) + $signed(psum_e[16 +: EW]);

        if (zero_d_reg)
            ease_e = EW'(ONE_Q);
        else
        begin
            unique case (ece_mode_t'(carry_d_reg.mode))
                MODE_OUT_BACK: ease_e = eback_reg;
                MODE_OUT_ELAS: ease_e = eelas_e;
                MODE_OUT_BNC:  ease_e = $signed(ebnc_d_reg);
                default:       ease_e = esimp_d_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ease_reg    <= ease_e;
            carry_e_reg <= carry_d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    assign out_valid = valid_reg[4];
    assign out_ease  = ease_reg;
    assign out_carry = carry_e_reg;

endmodule

>>> design/ece_blend.sv
// Blend stage: start + delta * eased fraction, saturated, into the output register.
// Depends on: ece_pkg.
module ece_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ece_pkg::EW-1:0] in_ease,
    input  ece_pkg::ece_carry_t           in_carry,
    output logic                          out_valid,
    output ece_pkg::ece_out_t             out_word
);
    import ece_pkg::*;

    localparam int SW = VALUE_BITS + 4;
    localparam logic signed [SW-1:0] VMAX = SW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] VMIN = -VMAX - SW'(1);

    logic                             mid_valid_reg;
    logic signed [VALUE_BITS+2:0]     dh_reg;
    logic signed [VALUE_BITS+16:0]    dl_reg;
    logic signed [VALUE_BITS-1:0]     start_reg;

    logic signed [2:0]                eh;
    logic signed [VALUE_BITS+17:0]    dl_sum;
    logic signed [SW-1:0]             sum;
    ece_out_t                         word_next;

    logic     out_valid_reg;
    ece_out_t out_word_reg;

    assign eh = in_ease[EW-1:FRAC_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dh_reg    <= in_carry.delta_value * eh;
            dl_reg    <= in_carry.delta_value * $signed({1'b0, in_ease[FRAC_BITS-1:0]});
            start_reg <= in_carry.start_value;
        end
    end

    always_comb
    begin
        dl_sum = (VALUE_BITS+18)'(dl_reg) + (VALUE_BITS+18)'(32768);
        // rounded low product keeps its sign when widened
        sum    = SW'(start_reg) + SW'(dh_reg) + SW'($signed(dl_sum[VALUE_BITS+17:16]));
        priority if (sum > VMAX)
        begin
            word_next.eased_value = VMAX[VALUE_BITS-1:0];
            word_next.saturated   = 1'b1;
        end
        else if (sum < VMIN)
        begin
            word_next.eased_value = VMIN[VALUE_BITS-1:0];
            word_next.saturated   = 1'b1;
        end
        else
        begin
            word_next.eased_value = sum[VALUE_BITS-1:0];
            word_next.saturated   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> design/easing_curve_evaluator.sv
// Easing curve evaluator top level: divider, shaper and blend pipelines.
// Depends on: ece_pkg, ece_divider, ece_shaper, ece_blend, assertion macros.
//
// Evaluates the classic easing curves (linear, quadratic in/out/in-out,
// out-back, out-elastic, out-bounce) on a fixed-point animation sample.
// Each input word carries mode, elapsed, span, start_value and delta_value;
// the result word is start_value + delta_value * eased(elapsed/span),
// signed Q16.16, clipped to the 32-bit range with saturated flagging a clip.
// Elapsed past span is clamped to span; a zero span yields the end value;
// the unused mode code behaves as linear. The block is a fully pipelined
// datapath with no state between samples: one word is accepted per clock
// while sample_stall is low, and each result passes through 18 stages of
// the bit-per-stage fraction divider, 5 shaper stages and 2 blend stages,
// the last being the output register. The whole pipeline advances together;
// sample_stall rises only while a result sits in the output register and
// result_stall is high, so no word is lost or repeated across stalls.
`include "easing_curve_evaluator_assert.svh"
module easing_curve_evaluator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  ece_pkg::ece_in_t  sample,
    output logic              result_valid,
    input  logic              result_stall,
    output ece_pkg::ece_out_t result
);
    import ece_pkg::*;

    logic        en;            // pipeline advance
    ece_carry_t  carry_in;

    logic        div_valid;
    logic [FW-1:0] div_frac;
    logic        div_zero;
    ece_carry_t  div_carry;

    logic        shp_valid;
    logic signed [EW-1:0] shp_ease;
    ece_carry_t  shp_carry;

    // advance whenever the output register is empty or being drained
    assign en           = !result_valid || !result_stall;
    assign sample_stall = !en;

    assign carry_in.mode        = sample.mode;
    assign carry_in.start_value = sample.start_value;
    assign carry_in.delta_value = sample.delta_value;

    ece_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sample_valid),
        .in_elapsed (sample.elapsed),
        .in_span    (sample.span),
        .in_carry   (carry_in),
        .out_valid  (div_valid),
        .out_frac   (div_frac),
        .out_zero   (div_zero),
        .out_carry  (div_carry)
    );

    ece_shaper u_shp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_frac   (div_frac),
        .in_zero   (div_zero),
        .in_carry  (div_carry),
        .out_valid (shp_valid),
        .out_ease  (shp_ease),
        .out_carry (shp_carry)
    );

    ece_blend u_bld (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (shp_valid),
        .in_ease   (shp_ease),
        .in_carry  (shp_carry),
        .out_valid (result_valid),
        .out_word  (result)
    );

    // a held result freezes the whole pipeline, input side included
    `ECE_ASSERT_IMP(a_stall_backs_up, result_valid && result_stall, sample_stall, "pipeline not frozen")
    // a clipped result sits exactly on a range limit
    `ECE_ASSERT_IMP(a_sat_at_limit, result_valid && result.saturated, (result.eased_value == {1'b0, {(VALUE_BITS-1){1'b1}}}) || (result.eased_value == {1'b1, {(VALUE_BITS-1){1'b0}}}), "saturated off limit")

endmodule

>>> dv/ece_checker.sv
// Checker for the easing curve evaluator: predicts each result word from the
// accepted sample words and compares in order. Depends on: ece_pkg.
module ece_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    input  logic              sample_stall,
    input  ece_pkg::ece_in_t  sample,
    input  logic              result_valid,
    input  logic              result_stall,
    input  ece_pkg::ece_out_t result,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ece_pkg::*;

    ece_out_t expected_q[$];

    localparam longint SINE_PTS [17] = '{0, 6424, 12785, 19024, 25080, 30893, 36410,
        41576, 46341, 50660, 54491, 57798, 60547, 62714, 64277, 65220, 65536};
    localparam longint POW_PTS [17] = '{65536, 62757, 60097, 57549, 55109, 52773,
        50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};

    // Q.32 -> Q.16, round half up (floor of x + 0.5)
    function automatic longint rnd16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint sine_of(longint ph);
        longint q, r, x, i, fr, v;
        q = (ph >> 14) & 3;
        r = ph & 16'h3FFF;
        x = q[0] ? 16384 - r : r;
        i = x >> 10;
        fr = x & 1023;
        if (i >= 16) v = 65536;
        else v = SINE_PTS[i] + (((SINE_PTS[i+1] - SINE_PTS[i]) * fr + 512) >>> 10);
        return (q >= 2) ? -v : v;
    endfunction

    function automatic longint decay_of(longint f);
        longint e, n, fr, idx, f2, v;
        e = f * 10;
        n = e >> 16;
        fr = e & 16'hFFFF;
        idx = fr >> 12;
        f2 = fr & 4095;
        v = POW_PTS[idx] - (((POW_PTS[idx] - POW_PTS[idx+1]) * f2 + 2048) >>> 12);
        if (n > 16) n = 16;
        return v >> n;
    endfunction

    function automatic longint eased_fraction(logic [2:0] m, longint f);
        longint g, f11, w, base;
        g = 65536 - f;
        case (ece_mode_t'(m))
            MODE_IN_QUAD:  return rnd16(f * f);
            MODE_OUT_QUAD: return 65536 - rnd16(g * g);
            MODE_IO_QUAD:  return (f < 32768) ? rnd16(2 * f * f) : 65536 - rnd16(2 * g * g);
            MODE_OUT_BACK: return 65536 + rnd16(rnd16(g * g) * (111514 - rnd16(177050 * g)));
            MODE_OUT_ELAS:
            begin
                if (f == 0) return 0;
                if (f >= 65536) return 65536;
                return 65536 + rnd16(decay_of(f) * sine_of((f * 10 / 3 + 49152) & 16'hFFFF));
            end
            MODE_OUT_BNC:
            begin
                f11 = 11 * f;
                if (f11 < 4 * 65536)       begin w = f11;              base = 0;     end
                else if (f11 < 8 * 65536)  begin w = f11 - 6 * 65536;  base = 49152; end
                else if (f11 < 10 * 65536) begin w = f11 - 9 * 65536;  base = 61440; end
                else                       begin w = f11 - 688128;     base = 64512; end
                if (w < 0) w = -w;
                return ((w * w + (64'd1 << 19)) >> 20) + base;
            end
            default:       return f;
        endcase
    endfunction

    function automatic ece_out_t predict_eased(ece_in_t s);
        ece_out_t o;
        longint t, d, e, el, eh, sum, st, dl;
        t = s.elapsed;
        d = s.span;
        st = s.start_value;
        dl = s.delta_value;
        if (d == 0) e = 65536;
        else
        begin
            if (t > d) t = d;
            e = eased_fraction(s.mode, (t << 16) / d);
        end
        el = e & 16'hFFFF;
        eh = (e - el) / 65536;
        sum = st + dl * eh + rnd16(dl * el);
        o.saturated = 1'b0;
        if (sum > 64'sd2147483647) begin sum = 64'sd2147483647; o.saturated = 1'b1; end
        if (sum < -64'sd2147483648) begin sum = -64'sd2147483648; o.saturated = 1'b1; end
        o.eased_value = sum[31:0];
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        ece_out_t exp_w;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                expected_q.push_back(predict_eased(sample));
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %h", result);
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    if (exp_w.eased_value !== result.eased_value ||
                        exp_w.saturated !== result.saturated)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected value %0d sat %b, got %0d sat %b",
                                     exp_w.eased_value, exp_w.saturated,
                                     result.eased_value, result.saturated);
                    end
                end
            end
        end
    end
endmodule

>>> dv/tb.sv
// Testbench top for the easing curve evaluator: drives sample words,
// throttles both sides, gives the verdict. Depends on: ece_pkg, ece_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ece_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     sample_valid = 1'b0;
    logic     sample_stall;
    ece_in_t  sample = '0;
    logic     result_valid;
    logic     result_stall = 1'b0;
    ece_out_t result;
    int       fail_count;
    int       pending;

    // percent chance per cycle of sender gap / receiver stall
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    easing_curve_evaluator dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    ece_checker chk (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // receiver throttle
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // value with heavy weight on edge cases
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 20'sh80000);
            3: return {16'($signed($urandom_range(0, 511)) - 256), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(5))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom_range(1, 64));
            default: return 16'($urandom);
        endcase
    endfunction

    // present one word and hold it until taken; valid is dropped between words only in sender gaps
    task automatic send_word(ece_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample <= w;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
    endtask

    task automatic send_random(int n);
        ece_in_t w;
        for (int i = 0; i < n; i++)
        begin
            w.mode = 3'($urandom_range(7));
            w.span = pick_time();
            // mostly elapsed within span so the curve body is exercised
            if ($urandom_range(3) != 0 && w.span != 0)
                w.elapsed = 16'($urandom_range(0, w.span));
            else
                w.elapsed = pick_time();
            w.start_value = pick_value();
            w.delta_value = pick_value();
            send_word(w);
        end
    endtask

    initial
    begin
        ece_in_t w;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every mode at the curve ends, midpoint and beyond span
        for (int m = 0; m < 8; m++)
        begin
            w = '{mode: m[2:0], elapsed: 16'd0, span: 16'd100,
                  start_value: 32'sh0001_0000, delta_value: 32'sh0010_0000};
            send_word(w);
            w.elapsed = 16'd50;
            send_word(w);
            w.elapsed = 16'hFFFF;      // clamps to span
            send_word(w);
        end
        // zero span gives the end value
        send_word('{MODE_OUT_BACK, 16'd7, 16'd0, 32'sh0000_1000, 32'sh0002_0000});
        // saturation both ways
        send_word('{MODE_LINEAR, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        send_word('{MODE_LINEAR, 16'hFFFF, 16'hFFFF, 32'sh8000_0000, 32'sh8000_0000});
        // elastic with zero change, overshoot of out-back
        send_word('{MODE_OUT_ELAS, 16'd1, 16'hFFFF, 32'sh0, 32'sh0});
        send_word('{MODE_OUT_BACK, 16'd3, 16'd10, 32'sh7FFF_0000, 32'sh0100_0000});

        send_idle_pct = 0;  recv_stall_pct = 0;  send_random(420);
        send_idle_pct = 68; recv_stall_pct = 0;  send_random(420);
        send_idle_pct = 0;  recv_stall_pct = 68; send_random(420);
        send_idle_pct = 15; recv_stall_pct = 15; send_random(420);
        sample_valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("easing_curve_evaluator verification clean");
        else
            $display("easing_curve_evaluator verification failed");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("easing_curve_evaluator verification failed");
        $finish;
    end
endmodule
